// File: rtl/acs_pkg.sv
// Package for the accumulator step core.
// Holds the controller states, opcodes and the command/status structs shared by
// the controller, the datapath and the top level. No dependencies.
package acs_pkg;

    localparam logic [9:0] STACK_TOP_RESET = 10'd999;
    localparam int         PORT_INT        = 1;

    typedef enum logic [4:0] {
        OPC_NOP  = 5'd0,
        OPC_LDI  = 5'd1,
        OPC_LDM  = 5'd2,
        OPC_ST   = 5'd3,
        OPC_ADDX = 5'd4,
        OPC_ADDY = 5'd5,
        OPC_SUBX = 5'd6,
        OPC_SUBY = 5'd7,
        OPC_GET  = 5'd8,
        OPC_PUT  = 5'd9,
        OPC_TAX  = 5'd10,
        OPC_TAY  = 5'd11,
        OPC_TXA  = 5'd12,
        OPC_TYA  = 5'd13,
        OPC_JMP  = 5'd14,
        OPC_JZ   = 5'd15,
        OPC_JNZ  = 5'd16,
        OPC_CALL = 5'd17,
        OPC_RET  = 5'd18,
        OPC_INX  = 5'd19,
        OPC_DEX  = 5'd20,
        OPC_HALT = 5'd30
    } t_opc;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FETCH, ST_OPND, ST_MEMRD,
        ST_CALL_IR, ST_CALL_X, ST_CALL_Y, ST_CALL_TGT, ST_CALL_RET,
        ST_RET_PC, ST_RET_Y, ST_RET_X, ST_RET_IR, ST_RET_AC, ST_DONE
    } t_state;

    typedef enum logic [2:0] {A_PC, A_PC1, A_OPND, A_SP, A_SP1, A_LOAD, A_CLR} t_asel;
    typedef enum logic [2:0] {W_ZERO, W_AC, W_IR, W_X, W_Y, W_RET, W_LOAD} t_wsel;
    typedef enum logic [1:0] {PC_HOLD, PC_INC1, PC_INC2, PC_RD} t_pcsel;
    typedef enum logic [1:0] {SP_HOLD, SP_DEC, SP_INC} t_spsel;
    typedef enum logic [3:0] {
        AC_HOLD, AC_RD, AC_ADDX, AC_ADDY, AC_SUBX, AC_SUBY, AC_IN, AC_X, AC_Y
    } t_acsel;
    typedef enum logic [2:0] {X_HOLD, X_AC, X_RD, X_INC, X_DEC} t_xsel;
    typedef enum logic [1:0] {Y_HOLD, Y_AC, Y_RD} t_ysel;

    typedef struct packed {
        logic   mem_we;
        t_asel  asel;
        t_wsel  wsel;
        t_pcsel pc_sel;
        t_spsel sp_sel;
        t_acsel ac_sel;
        t_xsel  x_sel;
        t_ysel  y_sel;
        logic   ir_ld;
        logic   halt_set;
        logic   port_clr;
        logic   put_set;
        logic   used_set;
        logic   clr_adv;
        logic   cap_in;
    } t_cmd;

    typedef struct packed {
        t_opc opc;
        logic ac_zero;
        logic clr_last;
        logic halted;
    } t_stat;

endpackage

// File: rtl/accumulator_cpu_step_core.sv
// Top level of the accumulator step core: controller plus datapath.
// Depends on acs_pkg, acs_ctrl and acs_dpath.
//
//  channel  | handshake          | beat contents
//  ---------+--------------------+-----------------------------------------------
//  item in  | start, busy        | i_op, i_load_addr, i_load_word, i_port_in_value
//  result   | o_done (strobe)    | o_port_out_*, o_port_in_used, o_halted_flag,
//           |                    | o_pc_after
//  config   | i_cfg_we           | i_cfg_wdata (stack_top)
//
// Each kind of item (load, halted step, halt, no-operand or operand
// instruction, indirect load, call, return) runs a state sequence shaped by
// the single memory port of the word memory. A new item is taken the cycle
// after the strobe. After reset busy stays high while the memory is swept to
// zero. The receiver cannot stall; each beat stands for one cycle only.
module accumulator_cpu_step_core #(
    parameter int MEM_DEPTH  = 1024,
    parameter int WORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [9:0]         i_cfg_wdata,
    input  logic               i_op,
    input  logic [9:0]         i_load_addr,
    input  logic signed [31:0] i_load_word,
    input  logic signed [31:0] i_port_in_value,
    output logic               o_done,
    output logic               o_port_out_valid,
    output logic signed [31:0] o_port_out_value,
    output logic               o_port_out_is_char,
    output logic               o_port_in_used,
    output logic               o_halted_flag,
    output logic [9:0]         o_pc_after
);

    acs_pkg::t_cmd  cmd;
    acs_pkg::t_stat stat;
    logic           pvalid, pchar, pused;
    logic [31:0]    pvalue;

    acs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    acs_dpath #(
        .MEM_DEPTH  (MEM_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_load_addr     (i_load_addr),
        .i_load_word     (i_load_word),
        .i_port_in_value (i_port_in_value),
        .o_stat          (stat),
        .o_pvalid        (pvalid),
        .o_pvalue        (pvalue),
        .o_pchar         (pchar),
        .o_pused         (pused),
        .o_pc            (o_pc_after)
    );

    assign o_port_out_valid   = o_done & pvalid;
    assign o_port_out_value   = o_done ? pvalue : '0;
    assign o_port_out_is_char = o_done & pchar;
    assign o_port_in_used     = o_done & pused;
    assign o_halted_flag      = stat.halted;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result beat while idle");

    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_port_out_valid && o_port_in_used))
        else $error("put and get reported in one beat");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_halted_flag) && $past(i_rst_n) |-> o_halted_flag)
        else $error("halted flag dropped");

endmodule

// File: rtl/acs_ctrl.sv
// Controller state machine of the accumulator step core.
// Sequences memory accesses and register loads; depends on acs_pkg.
module acs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_op,
    input  acs_pkg::t_stat i_stat,
    output acs_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    acs_pkg::t_state r_state, n_state;
    acs_pkg::t_opc   r_opc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acs_pkg::ST_CLEAR;
            r_opc   <= acs_pkg::OPC_NOP;
        end else begin
            r_state <= n_state;
            if (r_state == acs_pkg::ST_FETCH) r_opc <= i_stat.opc;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            acs_pkg::ST_CLEAR: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.asel    = acs_pkg::A_CLR;
                o_cmd.wsel    = acs_pkg::W_ZERO;
                o_cmd.clr_adv = 1'b1;
                if (i_stat.clr_last) n_state = acs_pkg::ST_IDLE;
            end
            acs_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.port_clr = 1'b1;
                    o_cmd.cap_in   = 1'b1;
                    if (!i_op) begin
                        o_cmd.mem_we = 1'b1;
                        o_cmd.asel   = acs_pkg::A_LOAD;
                        o_cmd.wsel   = acs_pkg::W_LOAD;
                        n_state      = acs_pkg::ST_DONE;
                    end else if (i_stat.halted) begin
                        n_state = acs_pkg::ST_DONE;
                    end else begin
                        o_cmd.asel = acs_pkg::A_PC;
                        n_state    = acs_pkg::ST_FETCH;
                    end
                end
            end
            acs_pkg::ST_FETCH: begin
                o_cmd.ir_ld  = 1'b1;
                o_cmd.pc_sel = acs_pkg::PC_INC1;
                n_state      = acs_pkg::ST_DONE;
                case (i_stat.opc)
                    acs_pkg::OPC_HALT: begin
                        o_cmd.pc_sel   = acs_pkg::PC_HOLD;
                        o_cmd.halt_set = 1'b1;
                    end
                    acs_pkg::OPC_LDI, acs_pkg::OPC_LDM, acs_pkg::OPC_ST,
                    acs_pkg::OPC_PUT, acs_pkg::OPC_JMP, acs_pkg::OPC_JZ,
                    acs_pkg::OPC_JNZ: begin
                        o_cmd.pc_sel = acs_pkg::PC_HOLD;
                        o_cmd.asel   = acs_pkg::A_PC1;
                        n_state      = acs_pkg::ST_OPND;
                    end
                    acs_pkg::OPC_GET: begin
                        o_cmd.pc_sel   = acs_pkg::PC_INC2;
                        o_cmd.ac_sel   = acs_pkg::AC_IN;
                        o_cmd.used_set = 1'b1;
                    end
                    acs_pkg::OPC_ADDX: o_cmd.ac_sel = acs_pkg::AC_ADDX;
                    acs_pkg::OPC_ADDY: o_cmd.ac_sel = acs_pkg::AC_ADDY;
                    acs_pkg::OPC_SUBX: o_cmd.ac_sel = acs_pkg::AC_SUBX;
                    acs_pkg::OPC_SUBY: o_cmd.ac_sel = acs_pkg::AC_SUBY;
                    acs_pkg::OPC_TAX:  o_cmd.x_sel  = acs_pkg::X_AC;
                    acs_pkg::OPC_TAY:  o_cmd.y_sel  = acs_pkg::Y_AC;
                    acs_pkg::OPC_TXA:  o_cmd.ac_sel = acs_pkg::AC_X;
                    acs_pkg::OPC_TYA:  o_cmd.ac_sel = acs_pkg::AC_Y;
                    acs_pkg::OPC_INX:  o_cmd.x_sel  = acs_pkg::X_INC;
                    acs_pkg::OPC_DEX:  o_cmd.x_sel  = acs_pkg::X_DEC;
                    acs_pkg::OPC_CALL: begin
                        o_cmd.pc_sel = acs_pkg::PC_HOLD;
                        o_cmd.mem_we = 1'b1;
                        o_cmd.asel   = acs_pkg::A_SP;
                        o_cmd.wsel   = acs_pkg::W_AC;
                        o_cmd.sp_sel = acs_pkg::SP_DEC;
                        n_state      = acs_pkg::ST_CALL_IR;
                    end
                    acs_pkg::OPC_RET: begin
                        o_cmd.pc_sel = acs_pkg::PC_HOLD;
                        o_cmd.asel   = acs_pkg::A_SP1;
                        o_cmd.sp_sel = acs_pkg::SP_INC;
                        n_state      = acs_pkg::ST_RET_PC;
                    end
                    default: ;
                endcase
            end
            acs_pkg::ST_OPND: begin
                o_cmd.pc_sel = acs_pkg::PC_INC2;
                n_state      = acs_pkg::ST_DONE;
                case (r_opc)
                    acs_pkg::OPC_LDI: o_cmd.ac_sel = acs_pkg::AC_RD;
                    acs_pkg::OPC_LDM: begin
                        o_cmd.pc_sel = acs_pkg::PC_HOLD;
                        o_cmd.asel   = acs_pkg::A_OPND;
                        n_state      = acs_pkg::ST_MEMRD;
                    end
                    acs_pkg::OPC_ST: begin
                        o_cmd.mem_we = 1'b1;
                        o_cmd.asel   = acs_pkg::A_OPND;
                        o_cmd.wsel   = acs_pkg::W_AC;
                    end
                    acs_pkg::OPC_PUT: o_cmd.put_set = 1'b1;
                    acs_pkg::OPC_JMP: o_cmd.pc_sel  = acs_pkg::PC_RD;
                    acs_pkg::OPC_JZ:
                        if (i_stat.ac_zero) o_cmd.pc_sel = acs_pkg::PC_RD;
                    acs_pkg::OPC_JNZ:
                        if (!i_stat.ac_zero) o_cmd.pc_sel = acs_pkg::PC_RD;
                    default: ;
                endcase
            end
            acs_pkg::ST_MEMRD: begin
                o_cmd.ac_sel = acs_pkg::AC_RD;
                o_cmd.pc_sel = acs_pkg::PC_INC2;
                n_state      = acs_pkg::ST_DONE;
            end
            acs_pkg::ST_CALL_IR: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.asel   = acs_pkg::A_SP;
                o_cmd.wsel   = acs_pkg::W_IR;
                o_cmd.sp_sel = acs_pkg::SP_DEC;
                n_state      = acs_pkg::ST_CALL_X;
            end
            acs_pkg::ST_CALL_X: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.asel   = acs_pkg::A_SP;
                o_cmd.wsel   = acs_pkg::W_X;
                o_cmd.sp_sel = acs_pkg::SP_DEC;
                n_state      = acs_pkg::ST_CALL_Y;
            end
            acs_pkg::ST_CALL_Y: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.asel   = acs_pkg::A_SP;
                o_cmd.wsel   = acs_pkg::W_Y;
                o_cmd.sp_sel = acs_pkg::SP_DEC;
                n_state      = acs_pkg::ST_CALL_TGT;
            end
            acs_pkg::ST_CALL_TGT: begin
                o_cmd.asel = acs_pkg::A_PC1;
                n_state    = acs_pkg::ST_CALL_RET;
            end
            acs_pkg::ST_CALL_RET: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.asel   = acs_pkg::A_SP;
                o_cmd.wsel   = acs_pkg::W_RET;
                o_cmd.sp_sel = acs_pkg::SP_DEC;
                o_cmd.pc_sel = acs_pkg::PC_RD;
                n_state      = acs_pkg::ST_DONE;
            end
            acs_pkg::ST_RET_PC: begin
                o_cmd.pc_sel = acs_pkg::PC_RD;
                o_cmd.asel   = acs_pkg::A_SP1;
                o_cmd.sp_sel = acs_pkg::SP_INC;
                n_state      = acs_pkg::ST_RET_Y;
            end
            acs_pkg::ST_RET_Y: begin
                o_cmd.y_sel  = acs_pkg::Y_RD;
                o_cmd.asel   = acs_pkg::A_SP1;
                o_cmd.sp_sel = acs_pkg::SP_INC;
                n_state      = acs_pkg::ST_RET_X;
            end
            acs_pkg::ST_RET_X: begin
                o_cmd.x_sel  = acs_pkg::X_RD;
                o_cmd.asel   = acs_pkg::A_SP1;
                o_cmd.sp_sel = acs_pkg::SP_INC;
                n_state      = acs_pkg::ST_RET_IR;
            end
            acs_pkg::ST_RET_IR: begin
                o_cmd.ir_ld  = 1'b1;
                o_cmd.asel   = acs_pkg::A_SP1;
                o_cmd.sp_sel = acs_pkg::SP_INC;
                n_state      = acs_pkg::ST_RET_AC;
            end
            acs_pkg::ST_RET_AC: begin
                o_cmd.ac_sel = acs_pkg::AC_RD;
                n_state      = acs_pkg::ST_DONE;
            end
            acs_pkg::ST_DONE: begin
                o_done  = 1'b1;
                n_state = acs_pkg::ST_IDLE;
            end
            default: n_state = acs_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: rtl/acs_dpath.sv
// Datapath of the accumulator step core: word memory, AC/X/Y/IR, PC, SP.
// Driven by commands from acs_ctrl; depends on acs_pkg.
module acs_dpath #(
    parameter int MEM_DEPTH  = 1024,
    parameter int WORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acs_pkg::t_cmd      i_cmd,
    input  logic               i_cfg_we,
    input  logic [9:0]         i_cfg_wdata,
    input  logic [9:0]         i_load_addr,
    input  logic signed [31:0] i_load_word,
    input  logic signed [31:0] i_port_in_value,
    output acs_pkg::t_stat     o_stat,
    output logic               o_pvalid,
    output logic [31:0]        o_pvalue,
    output logic               o_pchar,
    output logic               o_pused,
    output logic [9:0]         o_pc
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic [WORD_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [WORD_WIDTH-1:0] r_rd, r_ac, r_x, r_y, r_ir, r_in;
    logic [WORD_WIDTH-1:0] n_ac, n_x, n_y, wdata;
    logic [AW-1:0]         r_pc, r_sp, r_clr, n_pc, n_sp, addr, rd_addr;
    logic                  r_halted, r_pvalid, r_pchar, r_pused;
    logic [31:0]           r_pv;
    logic [4:0]            rd_lo;

    assign rd_addr = AW'(r_rd);
    assign rd_lo   = r_rd[4:0];

    always_comb begin
        o_stat.opc = acs_pkg::OPC_NOP;
        if (r_rd[WORD_WIDTH-1:5] == '0) begin
            case (rd_lo)
                acs_pkg::OPC_LDI, acs_pkg::OPC_LDM, acs_pkg::OPC_ST,
                acs_pkg::OPC_ADDX, acs_pkg::OPC_ADDY, acs_pkg::OPC_SUBX,
                acs_pkg::OPC_SUBY, acs_pkg::OPC_GET, acs_pkg::OPC_PUT,
                acs_pkg::OPC_TAX, acs_pkg::OPC_TAY, acs_pkg::OPC_TXA,
                acs_pkg::OPC_TYA, acs_pkg::OPC_JMP, acs_pkg::OPC_JZ,
                acs_pkg::OPC_JNZ, acs_pkg::OPC_CALL, acs_pkg::OPC_RET,
                acs_pkg::OPC_INX, acs_pkg::OPC_DEX, acs_pkg::OPC_HALT:
                    o_stat.opc = acs_pkg::t_opc'(rd_lo);
                default: o_stat.opc = acs_pkg::OPC_NOP;
            endcase
        end
        o_stat.ac_zero  = (r_ac == '0);
        o_stat.clr_last = (r_clr == {AW{1'b1}});
        o_stat.halted   = r_halted;
    end

    always_comb begin
        case (i_cmd.asel)
            acs_pkg::A_PC:   addr = r_pc;
            acs_pkg::A_PC1:  addr = r_pc + AW'(1);
            acs_pkg::A_OPND: addr = rd_addr;
            acs_pkg::A_SP:   addr = r_sp;
            acs_pkg::A_SP1:  addr = r_sp + AW'(1);
            acs_pkg::A_LOAD: addr = AW'(i_load_addr);
            acs_pkg::A_CLR:  addr = r_clr;
            default:         addr = r_pc;
        endcase
        case (i_cmd.wsel)
            acs_pkg::W_AC:   wdata = r_ac;
            acs_pkg::W_IR:   wdata = r_ir;
            acs_pkg::W_X:    wdata = r_x;
            acs_pkg::W_Y:    wdata = r_y;
            acs_pkg::W_RET:  wdata = WORD_WIDTH'(r_pc + AW'(2));
            acs_pkg::W_LOAD: wdata = WORD_WIDTH'(i_load_word);
            default:         wdata = '0;
        endcase
        case (i_cmd.pc_sel)
            acs_pkg::PC_INC1: n_pc = r_pc + AW'(1);
            acs_pkg::PC_INC2: n_pc = r_pc + AW'(2);
            acs_pkg::PC_RD:   n_pc = rd_addr;
            default:          n_pc = r_pc;
        endcase
        case (i_cmd.sp_sel)
            acs_pkg::SP_DEC: n_sp = r_sp - AW'(1);
            acs_pkg::SP_INC: n_sp = r_sp + AW'(1);
            default:         n_sp = r_sp;
        endcase
        case (i_cmd.ac_sel)
            acs_pkg::AC_RD:   n_ac = r_rd;
            acs_pkg::AC_ADDX: n_ac = r_ac + r_x;
            acs_pkg::AC_ADDY: n_ac = r_ac + r_y;
            acs_pkg::AC_SUBX: n_ac = r_ac - r_x;
            acs_pkg::AC_SUBY: n_ac = r_ac - r_y;
            acs_pkg::AC_IN:   n_ac = r_in;
            acs_pkg::AC_X:    n_ac = r_x;
            acs_pkg::AC_Y:    n_ac = r_y;
            default:          n_ac = r_ac;
        endcase
        case (i_cmd.x_sel)
            acs_pkg::X_AC:  n_x = r_ac;
            acs_pkg::X_RD:  n_x = r_rd;
            acs_pkg::X_INC: n_x = r_x + WORD_WIDTH'(1);
            acs_pkg::X_DEC: n_x = r_x - WORD_WIDTH'(1);
            default:        n_x = r_x;
        endcase
        case (i_cmd.y_sel)
            acs_pkg::Y_AC: n_y = r_ac;
            acs_pkg::Y_RD: n_y = r_rd;
            default:       n_y = r_y;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[addr] <= wdata;
        end else begin
            r_rd <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_sp     <= AW'(acs_pkg::STACK_TOP_RESET);
            r_clr    <= '0;
            r_ac     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_ir     <= '0;
            r_halted <= 1'b0;
            r_pvalid <= 1'b0;
            r_pchar  <= 1'b0;
            r_pused  <= 1'b0;
            r_pv     <= '0;
        end else begin
            r_pc <= n_pc;
            r_sp <= i_cfg_we ? AW'(i_cfg_wdata) : n_sp;
            r_ac <= n_ac;
            r_x  <= n_x;
            r_y  <= n_y;
            if (i_cmd.ir_ld) r_ir <= r_rd;
            if (i_cmd.clr_adv) r_clr <= r_clr + AW'(1);
            if (i_cmd.halt_set) r_halted <= 1'b1;
            if (i_cmd.port_clr) begin
                r_pvalid <= 1'b0;
                r_pchar  <= 1'b0;
                r_pused  <= 1'b0;
                r_pv     <= '0;
            end
            if (i_cmd.put_set) begin
                r_pvalid <= 1'b1;
                r_pchar  <= (r_rd != WORD_WIDTH'(acs_pkg::PORT_INT));
                r_pv     <= 32'(r_ac);
            end
            if (i_cmd.used_set) r_pused <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) r_in <= WORD_WIDTH'(i_port_in_value);
    end

    assign o_pvalid = r_pvalid;
    assign o_pvalue = r_pv;
    assign o_pchar  = r_pchar;
    assign o_pused  = r_pused;
    assign o_pc     = 10'(r_pc);

endmodule

// File: bench/tb_accumulator_cpu_step_core.sv
// Self-checking bench for accumulator_cpu_step_core: loads short random programs, steps them
// and checks every result beat against a behavioral model of the core kept in the bench.
// Depends on acs_pkg and the RTL of the core.
`timescale 1ns / 100ps

module tb_accumulator_cpu_step_core;

    localparam int IDLE_WAIT = 20;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        bit          op;
        logic [9:0]  load_addr;
        logic [31:0] load_word;
        logic [31:0] port_in;
    } t_item;

    typedef struct {
        bit          out_valid;
        logic [31:0] out_value;
        bit          out_is_char;
        bit          in_used;
        bit          halted;
        logic [9:0]  pc;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [9:0]  i_cfg_wdata = '0;
    logic        i_op = 1'b0;
    logic [9:0]  i_load_addr = '0;
    logic signed [31:0] i_load_word = '0;
    logic signed [31:0] i_port_in_value = '0;
    logic        o_done;
    logic        o_port_out_valid;
    logic signed [31:0] o_port_out_value;
    logic        o_port_out_is_char;
    logic        o_port_in_used;
    logic        o_halted_flag;
    logic [9:0]  o_pc_after;

    accumulator_cpu_step_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_op(i_op), .i_load_addr(i_load_addr), .i_load_word(i_load_word),
        .i_port_in_value(i_port_in_value), .o_done(o_done),
        .o_port_out_valid(o_port_out_valid), .o_port_out_value(o_port_out_value),
        .o_port_out_is_char(o_port_out_is_char), .o_port_in_used(o_port_in_used),
        .o_halted_flag(o_halted_flag), .o_pc_after(o_pc_after)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model state of the core
    logic [31:0] cpu_mem [1024];
    logic [9:0]  cpu_pc;
    logic [9:0]  cpu_sp;
    logic [31:0] cpu_ac, cpu_x, cpu_y, cpu_ir;
    bit          cpu_halted;

    t_item pending_items[$];
    t_beat expected_beats[$];
    t_item cur_item;
    int    idle_pct = 0;
    int    n_errors = 0;
    int    n_loads = 0, n_steps = 0, n_puts = 0, n_gets = 0, n_checked = 0;
    int    stall_cnt = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH beat %0d %s: got %h expected %h", n_checked, what, got, want);
        n_errors++;
    endtask

    task automatic push_stack(input logic [31:0] w);
        cpu_mem[cpu_sp] = w;
        cpu_sp = cpu_sp - 10'd1;
    endtask

    task automatic pop_stack(output logic [31:0] w);
        cpu_sp = cpu_sp + 10'd1;
        w = cpu_mem[cpu_sp];
    endtask

    task automatic execute_item(input t_item it, output t_beat b);
        logic [9:0]  pc;
        logic [9:0]  tgt;
        logic [31:0] ir;
        logic [31:0] w;
        b = '{0, 32'd0, 0, 0, 0, 10'd0};
        if (!it.op) begin
            cpu_mem[it.load_addr] = it.load_word;
            n_loads++;
        end else if (!cpu_halted) begin
            n_steps++;
            pc = cpu_pc;
            ir = cpu_mem[pc];
            cpu_ir = ir;
            if (ir == 32'(acs_pkg::OPC_HALT)) begin
                cpu_halted = 1'b1;
            end else begin
                case (ir)
                    32'(acs_pkg::OPC_LDI): begin pc++; cpu_ac = cpu_mem[pc]; end
                    32'(acs_pkg::OPC_LDM): begin
                        pc++;
                        cpu_ac = cpu_mem[cpu_mem[pc][9:0]];
                    end
                    32'(acs_pkg::OPC_ST): begin
                        pc++;
                        cpu_mem[cpu_mem[pc][9:0]] = cpu_ac;
                    end
                    32'(acs_pkg::OPC_ADDX): cpu_ac = cpu_ac + cpu_x;
                    32'(acs_pkg::OPC_ADDY): cpu_ac = cpu_ac + cpu_y;
                    32'(acs_pkg::OPC_SUBX): cpu_ac = cpu_ac - cpu_x;
                    32'(acs_pkg::OPC_SUBY): cpu_ac = cpu_ac - cpu_y;
                    32'(acs_pkg::OPC_GET): begin
                        pc++;
                        cpu_ac = it.port_in;
                        b.in_used = 1;
                        n_gets++;
                    end
                    32'(acs_pkg::OPC_PUT): begin
                        pc++;
                        b.out_valid = 1;
                        b.out_value = cpu_ac;
                        b.out_is_char = (cpu_mem[pc] != 32'(acs_pkg::PORT_INT));
                        n_puts++;
                    end
                    32'(acs_pkg::OPC_TAX): cpu_x = cpu_ac;
                    32'(acs_pkg::OPC_TAY): cpu_y = cpu_ac;
                    32'(acs_pkg::OPC_TXA): cpu_ac = cpu_x;
                    32'(acs_pkg::OPC_TYA): cpu_ac = cpu_y;
                    32'(acs_pkg::OPC_JMP): pc = cpu_mem[pc + 10'd1][9:0] - 10'd1;
                    32'(acs_pkg::OPC_JZ): begin
                        pc++;
                        if (cpu_ac == 0) pc = cpu_mem[pc][9:0] - 10'd1;
                    end
                    32'(acs_pkg::OPC_JNZ): begin
                        pc++;
                        if (cpu_ac != 0) pc = cpu_mem[pc][9:0] - 10'd1;
                    end
                    32'(acs_pkg::OPC_CALL): begin
                        push_stack(cpu_ac);
                        push_stack(cpu_ir);
                        push_stack(cpu_x);
                        push_stack(cpu_y);
                        pc++;
                        tgt = cpu_mem[pc][9:0];
                        pc++;
                        push_stack({22'd0, pc});
                        pc = tgt - 10'd1;
                    end
                    32'(acs_pkg::OPC_RET): begin
                        pop_stack(w);
                        pc = w[9:0] - 10'd1;
                        pop_stack(cpu_y);
                        pop_stack(cpu_x);
                        pop_stack(cpu_ir);
                        pop_stack(cpu_ac);
                    end
                    32'(acs_pkg::OPC_INX): cpu_x = cpu_x + 32'd1;
                    32'(acs_pkg::OPC_DEX): cpu_x = cpu_x - 32'd1;
                    default: ;
                endcase
                cpu_pc = pc + 10'd1;
            end
        end
        b.halted = cpu_halted;
        b.pc = cpu_pc;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_beat b;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                execute_item(cur_item, b);
                expected_beats.push_back(b);
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                cur_item = pending_items.pop_front();
                i_op <= cur_item.op;
                i_load_addr <= cur_item.load_addr;
                i_load_word <= cur_item.load_word;
                i_port_in_value <= cur_item.port_in;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && o_done) begin
            if (expected_beats.size() == 0) begin
                $display("MISMATCH result beat with nothing expected, pc %h", o_pc_after);
                n_errors++;
            end else begin
                e = expected_beats.pop_front();
                if (o_port_out_valid !== e.out_valid)
                    report_mismatch("port_out_valid", 32'(o_port_out_valid), 32'(e.out_valid));
                if (o_port_out_value !== e.out_value)
                    report_mismatch("port_out_value", o_port_out_value, e.out_value);
                if (o_port_out_is_char !== e.out_is_char)
                    report_mismatch("port_out_is_char", 32'(o_port_out_is_char),
                                    32'(e.out_is_char));
                if (o_port_in_used !== e.in_used)
                    report_mismatch("port_in_used", 32'(o_port_in_used), 32'(e.in_used));
                if (o_halted_flag !== e.halted)
                    report_mismatch("halted_flag", 32'(o_halted_flag), 32'(e.halted));
                if (o_pc_after !== e.pc)
                    report_mismatch("pc_after", 32'(o_pc_after), 32'(e.pc));
                n_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic add_load(input logic [9:0] a, input logic [31:0] w);
        pending_items.push_back('{1'b0, a, w, $urandom()});
    endtask

    task automatic add_step(input logic [31:0] pin);
        pending_items.push_back('{1'b1, 10'($urandom()), $urandom(), pin});
    endtask

    task automatic drain;
        wait (pending_items.size() == 0 && expected_beats.size() == 0 && !start);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_stack_top(input logic [9:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cpu_sp = v;
    endtask

    function automatic logic [31:0] pick_opcode();
        int r;
        logic [31:0] w;
        r = $urandom_range(99);
        if (r < 88) return 32'($urandom_range(20));
        if (r < 94) return 32'($urandom_range(21, 29));
        w = $urandom();
        if (w <= 32'(acs_pkg::OPC_HALT)) w = 32'(acs_pkg::OPC_NOP);
        return w;
    endfunction

    // random program fragment at the current pc, then a run of steps over it
    task automatic add_fragment(input int steps);
        logic [9:0]  a;
        logic [31:0] opc, opnd;
        int i;
        a = cpu_pc;
        if ($urandom_range(3) == 0) add_load(10'($urandom()), $urandom());
        i = 0;
        while (i < 12) begin
            opc = pick_opcode();
            add_load(a + 10'(i), opc);
            i++;
            case (opc)
                32'(acs_pkg::OPC_JMP), 32'(acs_pkg::OPC_JZ), 32'(acs_pkg::OPC_JNZ),
                32'(acs_pkg::OPC_CALL): begin
                    opnd = {$urandom_range(3) == 0 ? 22'($urandom()) : 22'd0,
                            a + 10'($urandom_range(11))};
                    add_load(a + 10'(i), opnd);
                    i++;
                end
                32'(acs_pkg::OPC_PUT): begin
                    opnd = $urandom_range(1) ? 32'(acs_pkg::PORT_INT) : $urandom_range(3);
                    add_load(a + 10'(i), opnd);
                    i++;
                end
                32'(acs_pkg::OPC_LDI), 32'(acs_pkg::OPC_LDM), 32'(acs_pkg::OPC_ST),
                32'(acs_pkg::OPC_GET): begin
                    add_load(a + 10'(i), $urandom());
                    i++;
                end
                default: ;
            endcase
        end
        repeat (steps) add_step($urandom());
    endtask

    initial begin
        int phase_items;
        logic [9:0] top_vals [4];
        int idle_vals [4];
        top_vals = '{10'd1023, 10'd0, 10'($urandom()), acs_pkg::STACK_TOP_RESET};
        idle_vals = '{0, 48, 0, 29};
        for (int k = 0; k < 1024; k++) cpu_mem[k] = '0;
        cpu_pc = '0;
        cpu_sp = acs_pkg::STACK_TOP_RESET;
        cpu_ac = '0; cpu_x = '0; cpu_y = '0; cpu_ir = '0;
        cpu_halted = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: wrap-around add, zero jump, call and return, put as integer
        add_load(10'd1023, 32'h8000_0000);
        add_load(10'd0, 32'(acs_pkg::OPC_GET));  add_load(10'd1, 32'd0);
        add_load(10'd2, 32'(acs_pkg::OPC_TAX));  add_load(10'd3, 32'(acs_pkg::OPC_ADDX));
        add_load(10'd4, 32'(acs_pkg::OPC_JZ));   add_load(10'd5, 32'd6);
        add_load(10'd6, 32'(acs_pkg::OPC_CALL)); add_load(10'd7, 32'hFFFF_FC0A);
        add_load(10'd8, 32'(acs_pkg::OPC_PUT));  add_load(10'd9, 32'(acs_pkg::PORT_INT));
        add_load(10'd10, 32'(acs_pkg::OPC_DEX)); add_load(10'd11, 32'(acs_pkg::OPC_RET));
        add_step(32'h8000_0000);
        repeat (6) add_step(32'h7FFF_FFFF);
        add_step(32'hFFFF_FFFF);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_stack_top(top_vals[p]);
            idle_pct = idle_vals[p];
            phase_items = 0;
            while (phase_items < 480) begin
                add_fragment($urandom_range(4, 12));
                phase_items += pending_items.size();
                drain();
            end
        end

        // halt, then a step on the halted core and a load that still writes
        add_load(cpu_pc, 32'(acs_pkg::OPC_HALT));
        add_step($urandom());
        add_step($urandom());
        add_load(10'd1023, 32'h7FFF_FFFF);
        drain();

        $display("Covered %0d loads and %0d executed steps (%0d puts, %0d gets).",
                 n_loads, n_steps, n_puts, n_gets);
        $display("Checked %0d result beats with %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0 && expected_beats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/acs_pkg.sv
rtl/acs_ctrl.sv
rtl/acs_dpath.sv
rtl/accumulator_cpu_step_core.sv
bench/tb_accumulator_cpu_step_core.sv
